[rtl/jad_pkg.sv]
// Package with the shared types and constants of the joystick axis digitizer.
package jad_pkg;

    localparam int DEF_PADS            = 2;
    localparam int DEF_AXES_PER_PAD    = 8;
    localparam int DEF_BUTTONS_PER_PAD = 16;

    localparam int PAD_COUNT     = 2;
    localparam int SLOTS_PER_PAD = 8;
    localparam int SLOT_COUNT    = PAD_COUNT * SLOTS_PER_PAD;
    localparam int SLOT_BITS     = $clog2(SLOT_COUNT);
    localparam int AXIS_BITS     = $clog2(SLOTS_PER_PAD);
    localparam int QUEUE_DEPTH   = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE_MAP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_PAD0   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_PAD0  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_PAD1   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_PAD1  = 3'd4;

    localparam logic [31:0]        MODE_MAP_RESET = 32'h5555_5555;
    localparam logic signed [15:0] LOW_RESET      = -16'sd250;
    localparam logic signed [15:0] HIGH_RESET     = 16'sd250;

    localparam logic [1:0] MODE_DIGITAL = 2'd1;
    localparam logic [1:0] MODE_ANALOG  = 2'd2;

    typedef enum logic [1:0] {
        KIND_PLUS   = 2'd0,
        KIND_MINUS  = 2'd1,
        KIND_ANALOG = 2'd2,
        KIND_BUTTON = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        DIR_UNKNOWN = 2'd0,
        DIR_CENTER  = 2'd1,
        DIR_PLUS    = 2'd2,
        DIR_MINUS   = 2'd3
    } t_dir;

    // One classified input: one or two results that share pad and number.
    typedef struct packed {
        logic       two;
        t_kind      kind0;
        logic       rel0;
        t_kind      kind1;
        logic       rel1;
        logic       pad;
        logic [3:0] number;
        logic [7:0] level;
    } t_job;

endpackage

[rtl/jad_front.sv]
// Front end: configuration registers, direction state and event classification.
module jad_front #(
    parameter int PADS            = jad_pkg::DEF_PADS,
    parameter int AXES_PER_PAD    = jad_pkg::DEF_AXES_PER_PAD,
    parameter int BUTTONS_PER_PAD = jad_pkg::DEF_BUTTONS_PER_PAD
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_command,
    input  logic                               i_pad_index,
    input  logic [7:0]                         i_control_number,
    input  logic signed [15:0]                 i_sample_value,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [jad_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [jad_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_full,
    output logic                               o_push,
    output jad_pkg::t_job                      o_job
);

    logic [31:0]                 r_mode_map;
    logic signed [15:0]          r_low  [jad_pkg::PAD_COUNT];
    logic signed [15:0]          r_high [jad_pkg::PAD_COUNT];
    jad_pkg::t_dir               r_dir  [jad_pkg::SLOT_COUNT];

    logic                        accept;
    logic                        pad_ok;
    logic                        axis_ok;
    logic                        button_ok;
    logic [jad_pkg::SLOT_BITS-1:0] slot;
    logic [1:0]                  mode;
    jad_pkg::t_dir               old_dir;
    jad_pkg::t_dir               n_dir;
    logic                        dir_write;
    logic                        has_result;
    jad_pkg::t_job               job;

    assign accept      = i_in_valid && !i_full;
    assign o_in_stall  = i_full;
    assign o_cfg_ready = 1'b1;

    assign pad_ok    = 32'(i_pad_index) < PADS;
    assign axis_ok   = 32'(i_control_number) < AXES_PER_PAD;
    assign button_ok = 32'(i_control_number) < BUTTONS_PER_PAD;
    assign slot      = {i_pad_index, i_control_number[jad_pkg::AXIS_BITS-1:0]};
    assign mode      = r_mode_map[{slot, 1'b0} +: 2];
    assign old_dir   = r_dir[slot];

    always_comb begin
        if (i_sample_value > r_high[i_pad_index]) begin
            n_dir = jad_pkg::DIR_PLUS;
        end else if (i_sample_value < r_low[i_pad_index]) begin
            n_dir = jad_pkg::DIR_MINUS;
        end else begin
            n_dir = jad_pkg::DIR_CENTER;
        end
    end

    always_comb begin
        job        = '0;
        job.pad    = i_pad_index;
        job.number = i_control_number[3:0];
        job.kind0  = jad_pkg::KIND_BUTTON;
        job.kind1  = jad_pkg::KIND_BUTTON;
        has_result = 1'b0;
        dir_write  = 1'b0;
        if (pad_ok) begin
            if (i_command) begin
                if (button_ok) begin
                    has_result = 1'b1;
                    job.kind0  = jad_pkg::KIND_BUTTON;
                    job.rel0   = (i_sample_value == 16'sd0);
                end
            end else if (axis_ok) begin
                if (mode == jad_pkg::MODE_ANALOG) begin
                    has_result = 1'b1;
                    job.kind0  = jad_pkg::KIND_ANALOG;
                    // Adding the offset only flips the sign bit of the upper byte.
                    job.level  = {~i_sample_value[15], i_sample_value[14:8]};
                end else if (mode == jad_pkg::MODE_DIGITAL && n_dir != old_dir) begin
                    dir_write = 1'b1;
                    case (n_dir)
                        jad_pkg::DIR_PLUS: begin
                            has_result = 1'b1;
                            job.kind0  = jad_pkg::KIND_PLUS;
                            job.two    = (old_dir == jad_pkg::DIR_MINUS);
                            job.kind1  = jad_pkg::KIND_MINUS;
                            job.rel1   = 1'b1;
                        end
                        jad_pkg::DIR_MINUS: begin
                            has_result = 1'b1;
                            job.kind0  = jad_pkg::KIND_MINUS;
                            job.two    = (old_dir == jad_pkg::DIR_PLUS);
                            job.kind1  = jad_pkg::KIND_PLUS;
                            job.rel1   = 1'b1;
                        end
                        default: begin
                            // Back to center releases whatever was held.
                            has_result = (old_dir == jad_pkg::DIR_PLUS) ||
                                         (old_dir == jad_pkg::DIR_MINUS);
                            job.kind0  = (old_dir == jad_pkg::DIR_PLUS) ?
                                         jad_pkg::KIND_PLUS : jad_pkg::KIND_MINUS;
                            job.rel0   = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    assign o_push = accept && has_result;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_map <= jad_pkg::MODE_MAP_RESET;
            for (int p = 0; p < jad_pkg::PAD_COUNT; p++) begin
                r_low[p]  <= jad_pkg::LOW_RESET;
                r_high[p] <= jad_pkg::HIGH_RESET;
            end
            for (int s = 0; s < jad_pkg::SLOT_COUNT; s++) begin
                r_dir[s] <= jad_pkg::DIR_UNKNOWN;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    jad_pkg::REG_MODE_MAP:  r_mode_map <= i_cfg_data;
                    jad_pkg::REG_LOW_PAD0:  r_low[0]   <= i_cfg_data[15:0];
                    jad_pkg::REG_HIGH_PAD0: r_high[0]  <= i_cfg_data[15:0];
                    jad_pkg::REG_LOW_PAD1:  r_low[1]   <= i_cfg_data[15:0];
                    jad_pkg::REG_HIGH_PAD1: r_high[1]  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (accept && dir_write) begin
                r_dir[slot] <= n_dir;
            end
        end
    end

endmodule

[rtl/jad_queue.sv]
// Short queue of classified jobs between the front end and the result sequencer.
module jad_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jad_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output jad_pkg::t_job o_job
);

    localparam int DEPTH = jad_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jad_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/jad_back.sv]
// Back end: sequences each job into one or two registered result transfers.
module jad_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  jad_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_event_kind,
    output logic          o_out_pad,
    output logic [3:0]    o_out_number,
    output logic          o_released,
    output logic [7:0]    o_analog_level,
    output logic          o_last_of_run
);

    logic          r_out_valid;
    jad_pkg::t_kind r_kind;
    logic          r_pad;
    logic [3:0]    r_number;
    logic          r_rel;
    logic [7:0]    r_level;
    logic          r_last;
    logic          r_pend;
    jad_pkg::t_kind r_kind1;
    logic          r_rel1;
    logic          load;

    assign load  = !r_out_valid || !i_out_stall;
    assign o_pop = load && !r_pend && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else begin
                r_out_valid <= !i_empty;
                r_pend      <= !i_empty && i_job.two;
            end
        end
    end

    // The second result of a pair reuses pad and number from the first.
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_kind  <= r_kind1;
                r_rel   <= r_rel1;
                r_level <= '0;
                r_last  <= 1'b1;
            end else if (!i_empty) begin
                r_kind   <= i_job.kind0;
                r_rel    <= i_job.rel0;
                r_level  <= i_job.level;
                r_last   <= !i_job.two;
                r_pad    <= i_job.pad;
                r_number <= i_job.number;
                r_kind1  <= i_job.kind1;
                r_rel1   <= i_job.rel1;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_kind;
    assign o_out_pad      = r_pad;
    assign o_out_number   = r_number;
    assign o_released     = r_rel;
    assign o_analog_level = r_level;
    assign o_last_of_run  = r_last;

`ifndef SYNTHESIS
    a_pend_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_out_valid)
        else $error("second result pending without a first one on the output");

    a_pend_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pend) |-> !r_last)
        else $error("first result of a pair marked as last of run");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && r_pend) |=> (r_out_valid && r_last))
        else $error("second result of a pair did not follow the first");

    a_no_pop_while_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_pop)
        else $error("queue popped while a second result was pending");
`endif

endmodule

[rtl/joystick_axis_digitizer.sv]
// Top level of the joystick axis digitizer: front end, job queue and result sequencer.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   command, pad_index, control_number,
//                                                 sample_value
//   out      output     o_out_valid / i_out_stall event_kind, out_pad, out_number,
//                                                 released, analog_level, last_of_run
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An input item is classified in the cycle of its transfer; a new one can follow every cycle
// while the two-entry job queue has room. The output register sends one result per cycle while
// i_out_stall is low, so an item with two results occupies it for both, and that sets the sustained rate.
// The first result is registered in the job queue and then in the output register before it appears.
// Synchronous active-low reset clears direction state, queue and output valid, and loads
// configuration defaults. Output stalls back up into the queue and then into o_in_stall.
module joystick_axis_digitizer #(
    parameter int PADS            = jad_pkg::DEF_PADS,
    parameter int AXES_PER_PAD    = jad_pkg::DEF_AXES_PER_PAD,
    parameter int BUTTONS_PER_PAD = jad_pkg::DEF_BUTTONS_PER_PAD
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic                            i_pad_index,
    input  logic [7:0]                      i_control_number,
    input  logic signed [15:0]              i_sample_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_event_kind,
    output logic                            o_out_pad,
    output logic [3:0]                      o_out_number,
    output logic                            o_released,
    output logic [7:0]                      o_analog_level,
    output logic                            o_last_of_run,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [jad_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [jad_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic          push;
    logic          full;
    logic          pop;
    logic          empty;
    jad_pkg::t_job front_job;
    jad_pkg::t_job head_job;

    jad_front #(
        .PADS            (PADS),
        .AXES_PER_PAD    (AXES_PER_PAD),
        .BUTTONS_PER_PAD (BUTTONS_PER_PAD)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_pad_index      (i_pad_index),
        .i_control_number (i_control_number),
        .i_sample_value   (i_sample_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_full           (full),
        .o_push           (push),
        .o_job            (front_job)
    );

    jad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (head_job)
    );

    jad_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_kind   (o_event_kind),
        .o_out_pad      (o_out_pad),
        .o_out_number   (o_out_number),
        .o_released     (o_released),
        .o_analog_level (o_analog_level),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

[tb/tb.sv]
// Testbench for the joystick axis digitizer: directed and random event streams.
`timescale 1ns / 100ps

module tb;

    localparam logic CMD_AXIS   = 1'b0;
    localparam logic CMD_BUTTON = 1'b1;

    localparam logic [1:0] MODE_UNUSED   = 2'd0;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int SETTLE_CYCLES   = 8;

    typedef struct {
        jad_pkg::t_kind kind;
        logic           pad;
        logic [3:0]     number;
        logic           released;
        logic [7:0]     level;
        logic           last;
    } t_dpad_event;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic                            i_command;
    logic                            i_pad_index;
    logic [7:0]                      i_control_number;
    logic signed [15:0]              i_sample_value;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [1:0]                      o_event_kind;
    logic                            o_out_pad;
    logic [3:0]                      o_out_number;
    logic                            o_released;
    logic [7:0]                      o_analog_level;
    logic                            o_last_of_run;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [jad_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [jad_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    // Predictor state.
    logic [31:0]        mode_map;
    logic signed [15:0] low_thr [2];
    logic signed [15:0] high_thr [2];
    jad_pkg::t_dir      axis_dir [jad_pkg::SLOT_COUNT];

    t_dpad_event pending_events [$];
    int          fail_count;
    int          burst_left;
    bit          gaps_on;
    int          stall_pct;

    joystick_axis_digitizer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_pad_index      (i_pad_index),
        .i_control_number (i_control_number),
        .i_sample_value   (i_sample_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_kind     (o_event_kind),
        .o_out_pad        (o_out_pad),
        .o_out_number     (o_out_number),
        .o_released       (o_released),
        .o_analog_level   (o_analog_level),
        .o_last_of_run    (o_last_of_run),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void reset_predictor();
        mode_map    = jad_pkg::MODE_MAP_RESET;
        low_thr[0]  = jad_pkg::LOW_RESET;
        high_thr[0] = jad_pkg::HIGH_RESET;
        low_thr[1]  = jad_pkg::LOW_RESET;
        high_thr[1] = jad_pkg::HIGH_RESET;
        for (int s = 0; s < jad_pkg::SLOT_COUNT; s++) begin
            axis_dir[s] = jad_pkg::DIR_UNKNOWN;
        end
    endfunction

    function automatic void apply_reg(input logic [jad_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [jad_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            jad_pkg::REG_MODE_MAP:  mode_map    = data;
            jad_pkg::REG_LOW_PAD0:  low_thr[0]  = data[15:0];
            jad_pkg::REG_HIGH_PAD0: high_thr[0] = data[15:0];
            jad_pkg::REG_LOW_PAD1:  low_thr[1]  = data[15:0];
            jad_pkg::REG_HIGH_PAD1: high_thr[1] = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic t_dpad_event make_event(input jad_pkg::t_kind kind, input logic pad,
                                               input logic [3:0] number, input logic rel,
                                               input logic [7:0] level);
        t_dpad_event ev;
        ev.kind     = kind;
        ev.pad      = pad;
        ev.number   = number;
        ev.released = rel;
        ev.level    = level;
        ev.last     = 1'b0;
        return ev;
    endfunction

    // Queues the results that one event causes. Returns 0 when the block drops the event.
    function automatic bit digitize_event(input logic cmd, input logic pad,
                                          input logic [7:0] num,
                                          input logic signed [15:0] val);
        t_dpad_event   outs [2];
        int            n;
        logic [3:0]    slot;
        logic [1:0]    mode;
        jad_pkg::t_dir old_dir;
        jad_pkg::t_dir new_dir;
        int            wide;
        n = 0;
        if (cmd == CMD_BUTTON) begin
            if (num >= jad_pkg::DEF_BUTTONS_PER_PAD) return 1'b0;
            outs[n] = make_event(jad_pkg::KIND_BUTTON, pad, num[3:0], val == 16'sd0, 8'd0);
            n++;
        end else begin
            if (num >= jad_pkg::DEF_AXES_PER_PAD) return 1'b0;
            slot = {pad, num[2:0]};
            mode = mode_map[2*slot +: 2];
            if (mode == jad_pkg::MODE_ANALOG) begin
                wide    = val;
                outs[n] = make_event(jad_pkg::KIND_ANALOG, pad, num[3:0], 1'b0,
                                     8'((wide + 32768) >>> 8));
                n++;
            end else if (mode == jad_pkg::MODE_DIGITAL) begin
                // The plus test comes first, so it wins when the thresholds cross.
                if (val > high_thr[pad]) begin
                    new_dir = jad_pkg::DIR_PLUS;
                end else if (val < low_thr[pad]) begin
                    new_dir = jad_pkg::DIR_MINUS;
                end else begin
                    new_dir = jad_pkg::DIR_CENTER;
                end
                old_dir = axis_dir[slot];
                if (new_dir != old_dir) begin
                    axis_dir[slot] = new_dir;
                    case (new_dir)
                        jad_pkg::DIR_PLUS: begin
                            outs[n] = make_event(jad_pkg::KIND_PLUS, pad, num[3:0],
                                                 1'b0, 8'd0);
                            n++;
                            if (old_dir == jad_pkg::DIR_MINUS) begin
                                outs[n] = make_event(jad_pkg::KIND_MINUS, pad, num[3:0],
                                                     1'b1, 8'd0);
                                n++;
                            end
                        end
                        jad_pkg::DIR_MINUS: begin
                            outs[n] = make_event(jad_pkg::KIND_MINUS, pad, num[3:0],
                                                 1'b0, 8'd0);
                            n++;
                            if (old_dir == jad_pkg::DIR_PLUS) begin
                                outs[n] = make_event(jad_pkg::KIND_PLUS, pad, num[3:0],
                                                     1'b1, 8'd0);
                                n++;
                            end
                        end
                        default: begin
                            if (old_dir == jad_pkg::DIR_PLUS) begin
                                outs[n] = make_event(jad_pkg::KIND_PLUS, pad, num[3:0],
                                                     1'b1, 8'd0);
                                n++;
                            end else if (old_dir == jad_pkg::DIR_MINUS) begin
                                outs[n] = make_event(jad_pkg::KIND_MINUS, pad, num[3:0],
                                                     1'b1, 8'd0);
                                n++;
                            end
                        end
                    endcase
                end
            end else begin
                return 1'b0;
            end
        end
        for (int k = 0; k < n; k++) begin
            outs[k].last = (k == n - 1);
            pending_events.push_back(outs[k]);
        end
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] pick_sample(input logic pad);
        int lo;
        int hi;
        lo = low_thr[pad];
        hi = high_thr[pad];
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return clamp16(hi + int'($urandom_range(1, 3000)));
            2: return clamp16(lo - int'($urandom_range(1, 3000)));
            3: begin
                if (lo <= hi) return clamp16(lo + int'($urandom_range(0, hi - lo)));
                return 16'($urandom);
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: return clamp16(hi);
                    1: return clamp16(lo);
                    2: return clamp16(hi + 1);
                    default: return clamp16(lo - 1);
                endcase
            end
            default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    function automatic logic [31:0] random_mode_map();
        logic [31:0] map;
        int          r;
        for (int s = 0; s < jad_pkg::SLOT_COUNT; s++) begin
            r = $urandom_range(0, 19);
            if (r < 12) begin
                map[2*s +: 2] = jad_pkg::MODE_DIGITAL;
            end else if (r < 17) begin
                map[2*s +: 2] = jad_pkg::MODE_ANALOG;
            end else if (r < 19) begin
                map[2*s +: 2] = MODE_UNUSED;
            end else begin
                map[2*s +: 2] = MODE_RESERVED;
            end
        end
        return map;
    endfunction

    // Receiver: stalls in runs of random length.
    initial begin : out_stall_pattern
        int  run_left;
        bit  stall_now;
        run_left    = 0;
        stall_now   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0) begin
                stall_now = ($urandom_range(0, 99) < stall_pct);
                run_left  = $urandom_range(1, 8);
            end
            run_left--;
            i_out_stall = stall_now;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_dpad_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                note_failure($sformatf({"unexpected result: kind=%0d pad=%0d num=%0d ",
                    "rel=%0d level=%0d last=%0d"},
                    o_event_kind, o_out_pad, o_out_number, o_released, o_analog_level,
                    o_last_of_run));
            end else begin
                want = pending_events.pop_front();
                if (o_event_kind !== want.kind || o_out_pad !== want.pad
                        || o_out_number !== want.number || o_released !== want.released
                        || o_analog_level !== want.level || o_last_of_run !== want.last) begin
                    note_failure($sformatf({"result mismatch: expected kind=%0d pad=%0d num=%0d ",
                        "rel=%0d level=%0d last=%0d, got kind=%0d pad=%0d num=%0d rel=%0d ",
                        "level=%0d last=%0d"},
                        want.kind, want.pad, want.number, want.released, want.level, want.last,
                        o_event_kind, o_out_pad, o_out_number, o_released, o_analog_level,
                        o_last_of_run));
                end
            end
        end
    end

    // Sends one event and predicts its results at the transfer. Returns 0 for a dropped event.
    task automatic send_event(input logic cmd, input logic pad, input logic [7:0] num,
                              input logic signed [15:0] val, output bit handled);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_in_valid       = 1'b1;
        i_command        = cmd;
        i_pad_index      = pad;
        i_control_number = num;
        i_sample_value   = val;
        do @(posedge i_clk); while (o_in_stall);
        handled = digitize_event(cmd, pad, num, val);
        burst_left--;
    endtask

    task automatic send(input logic cmd, input logic pad, input logic [7:0] num,
                        input logic signed [15:0] val);
        bit handled;
        send_event(cmd, pad, num, val, handled);
    endtask

    // Lets every expected result arrive, then keeps waiting so that events that cause none can pass.
    task automatic wait_until_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [jad_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [jad_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Upper data bits are random; only the low half should be taken.
    task automatic write_thresholds(input logic pad, input logic signed [15:0] lo,
                                    input logic signed [15:0] hi);
        write_reg(pad ? jad_pkg::REG_LOW_PAD1 : jad_pkg::REG_LOW_PAD0, {16'($urandom), lo});
        write_reg(pad ? jad_pkg::REG_HIGH_PAD1 : jad_pkg::REG_HIGH_PAD0, {16'($urandom), hi});
    endtask

    task automatic test_digital_transitions();
        send(CMD_AXIS, 1'b0, 8'd0, 16'sd0);
        send(CMD_AXIS, 1'b0, 8'd0, 16'sh7FFF);
        send(CMD_AXIS, 1'b0, 8'd0, 16'sh8000);
        send(CMD_AXIS, 1'b0, 8'd0, 16'sd0);
        send(CMD_AXIS, 1'b1, 8'd7, -16'sd251);
        send(CMD_AXIS, 1'b1, 8'd7, 16'sd250);
        send(CMD_AXIS, 1'b1, 8'd6, 16'sd251);
    endtask

    task automatic test_buttons_and_range();
        send(CMD_BUTTON, 1'b0, 8'd0, 16'sd0);
        send(CMD_BUTTON, 1'b1, 8'd15, 16'sh8000);
        send(CMD_BUTTON, 1'b0, 8'd16, 16'sd1);
        send(CMD_BUTTON, 1'b1, 8'd255, 16'sd1);
        send(CMD_AXIS, 1'b0, 8'd8, 16'sh7FFF);
        send(CMD_AXIS, 1'b1, 8'd255, 16'sh8000);
    endtask

    task automatic test_mode_map();
        wait_until_idle();
        // Axis 0 analog, axis 1 unused, axis 2 reserved mode, the rest digital.
        write_reg(jad_pkg::REG_MODE_MAP, 32'h5555_5572);
        send(CMD_AXIS, 1'b0, 8'd0, 16'sh8000);
        send(CMD_AXIS, 1'b0, 8'd0, 16'sh7FFF);
        send(CMD_AXIS, 1'b0, 8'd0, -16'sd1);
        send(CMD_AXIS, 1'b0, 8'd1, 16'sh7FFF);
        send(CMD_AXIS, 1'b0, 8'd2, 16'sh8000);
        wait_until_idle();
        // Back to digital: axis 0 still holds its old center direction.
        write_reg(jad_pkg::REG_MODE_MAP, jad_pkg::MODE_MAP_RESET);
        send(CMD_AXIS, 1'b0, 8'd0, 16'sd0);
        send(CMD_AXIS, 1'b0, 8'd0, 16'sh8000);
        wait_until_idle();
        write_reg(jad_pkg::REG_MODE_MAP, 32'h0000_0000);
        send(CMD_AXIS, 1'b0, 8'd0, 16'sh7FFF);
        wait_until_idle();
        write_reg(jad_pkg::REG_MODE_MAP, 32'hFFFF_FFFF);
        send(CMD_AXIS, 1'b0, 8'd0, 16'sh7FFF);
    endtask

    task automatic test_thresholds();
        wait_until_idle();
        write_reg(jad_pkg::REG_MODE_MAP, jad_pkg::MODE_MAP_RESET);
        write_thresholds(1'b0, 16'sh7FFF, 16'sh8000);
        write_thresholds(1'b1, 16'sh8000, 16'sh7FFF);
        send(CMD_AXIS, 1'b0, 8'd3, 16'sd0);
        send(CMD_AXIS, 1'b0, 8'd0, 16'sd0);
        send(CMD_AXIS, 1'b1, 8'd7, 16'sh8000);
        send(CMD_AXIS, 1'b1, 8'd7, 16'sh7FFF);
        send(CMD_AXIS, 1'b1, 8'd6, 16'sd0);
    endtask

    task automatic test_random_traffic();
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic               cmd;
        logic               pad;
        logic [7:0]         num;
        logic signed [15:0] val;
        int                 counted;
        int                 r;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_until_idle();
            write_reg(jad_pkg::REG_MODE_MAP,
                      (phase == 0) ? jad_pkg::MODE_MAP_RESET : random_mode_map());
            for (int p = 0; p < 2; p++) begin
                if (phase == 0) begin
                    lo = jad_pkg::LOW_RESET;
                    hi = jad_pkg::HIGH_RESET;
                end else begin
                    case ($urandom_range(0, 3))
                        0: begin
                            lo = 16'($urandom);
                            hi = 16'($urandom);
                        end
                        1: begin
                            lo = clamp16(int'($urandom_range(0, 4000)));
                            hi = clamp16(-int'($urandom_range(0, 4000)));
                        end
                        default: begin
                            lo = clamp16(-int'($urandom_range(0, 8000)));
                            hi = clamp16(int'($urandom_range(0, 8000)));
                        end
                    endcase
                end
                write_thresholds(p[0], lo, hi);
            end
            gaps_on   = (phase != 2);
            stall_pct = (phase == 2) ? 0 : ((phase == 4) ? 75 : 35);
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                r   = $urandom_range(0, 99);
                pad = 1'($urandom);
                if (r < 8) begin
                    cmd = 1'($urandom);
                    num = 8'($urandom);
                    val = 16'($urandom);
                end else if (r < 25) begin
                    cmd = CMD_BUTTON;
                    num = 8'($urandom_range(0, 15));
                    val = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom);
                end else begin
                    cmd = CMD_AXIS;
                    num = 8'($urandom_range(0, 7));
                    val = pick_sample(pad);
                end
                send(cmd, pad, num, val);
                counted++;
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_command        = CMD_AXIS;
        i_pad_index      = 1'b0;
        i_control_number = 8'd0;
        i_sample_value   = 16'sd0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = jad_pkg::REG_MODE_MAP;
        i_cfg_data       = '0;
        fail_count       = 0;
        burst_left       = 0;
        gaps_on          = 1'b1;
        stall_pct        = 30;
        reset_predictor();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_digital_transitions();
        test_buttons_and_range();
        test_mode_map();
        test_thresholds();
        test_random_traffic();

        wait_until_idle();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/jad_pkg.sv
rtl/jad_front.sv
rtl/jad_queue.sv
rtl/jad_back.sv
rtl/joystick_axis_digitizer.sv
tb/tb.sv
